[rtl/fctc_pkg.sv]
// Package for the four-channel counter/timer: channel count, operation codes,
// control-word bits, reset values and the types shared by the cells and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fctc_pkg;

  // Number of channels built (1 to 4); the channel field is always 2 bits.
  localparam int CHANNELS = 4;
  localparam int CHAN_W   = 2;
  localparam int BYTE_W   = 8;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Control word bits (bit 0 set marks a control word)
  localparam int CW_CONTROL = 0;
  localparam int CW_TC_NEXT = 2;
  localparam int CW_RANGE   = 5;
  localparam int CW_IRQ_EN  = 7;

  // Reset and reload values
  localparam logic [BYTE_W-1:0] COUNT_RESET    = 8'd255;
  localparam logic [BYTE_W-1:0] PRESCALE_LONG  = 8'd255;
  localparam logic [BYTE_W-1:0] PRESCALE_SHORT = 8'd15;

  // Command broadcast to every cell
  typedef struct packed {
    logic              tick;
    logic              write;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] data;
  } cell_cmd_t;

  // Interrupt priority chain, passed from the highest channel down to channel 0
  typedef struct packed {
    logic              fired;
    logic [BYTE_W-1:0] vector;
  } irq_chain_t;

endpackage

`default_nettype wire

[rtl/fctc_cell.sv]
// One counter/timer channel: prescaler, main down-counter, control and vector
// registers, plus its link in the interrupt priority chain. Depends on fctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fctc_cell
  import fctc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CHAN_W-1:0] index,
  input  wire cell_cmd_t         cmd,
  input  wire irq_chain_t        chain_in,
  output irq_chain_t             chain_out,
  output logic [BYTE_W-1:0]      count
);

  logic              irq_enable;
  logic              constant_pending;
  logic [BYTE_W-1:0] time_constant;
  logic [BYTE_W-1:0] vector_reg;
  logic [BYTE_W-1:0] main_count;
  logic [BYTE_W-1:0] prescale_reload;
  logic [BYTE_W-1:0] prescale_count;

  logic              step;
  logic              selected;
  logic [BYTE_W-1:0] prescale_dec;
  logic [BYTE_W-1:0] main_dec;
  logic              prescale_zero;
  logic              fire;

  // Tick arithmetic
  assign step          = cmd.tick && irq_enable;
  assign selected      = cmd.write && (cmd.channel == index);
  assign prescale_dec  = prescale_count - 8'd1;
  assign main_dec      = main_count - 8'd1;
  assign prescale_zero = (prescale_dec == '0);
  assign fire          = step && prescale_zero && (main_dec == '0);

  // Priority chain: a firing channel overrides any higher-numbered one
  assign chain_out.fired  = fire || chain_in.fired;
  assign chain_out.vector = fire ? vector_reg : chain_in.vector;

  assign count = main_count;

  // Channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable       <= 1'b0;
      constant_pending <= 1'b0;
      time_constant    <= COUNT_RESET;
      vector_reg       <= '0;
      main_count       <= COUNT_RESET;
      prescale_reload  <= PRESCALE_LONG;
      prescale_count   <= COUNT_RESET;
    end else begin
      if (step) begin
        if (!prescale_zero) begin
          prescale_count <= prescale_dec;
        end else begin
          prescale_count <= prescale_reload;
          main_count     <= (main_dec == '0) ? time_constant : main_dec;
        end
      end
      if (selected) begin
        if (constant_pending) begin
          time_constant    <= cmd.data;
          constant_pending <= 1'b0;
        end else if (cmd.data[CW_CONTROL]) begin
          irq_enable       <= cmd.data[CW_IRQ_EN];
          constant_pending <= cmd.data[CW_TC_NEXT];
          prescale_reload  <= cmd.data[CW_RANGE] ? PRESCALE_LONG : PRESCALE_SHORT;
        end else begin
          vector_reg <= {cmd.data[7:3], index, 1'b0};
        end
      end
    end
  end

  // A disabled channel never fires
  a_no_fire_disabled: assert property (@(posedge clk) disable iff (rst)
    !irq_enable |-> !fire)
    else $error("disabled channel fired");

  // Firing reloads the main count from the time constant
  a_fire_reload: assert property (@(posedge clk) disable iff (rst)
    fire && !selected |=> main_count == $past(time_constant))
    else $error("main count not reloaded on expiry");

  // A tick and a write are never broadcast together
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.tick && cmd.write))
    else $error("tick and write issued together");

endmodule

`default_nettype wire

[rtl/four_channel_counter_timer.sv]
// Top level of the four-channel counter/timer: item decode, the row of channel
// cells with its interrupt priority chain, and the output register.
// Depends on fctc_pkg and fctc_cell.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item (tick, count read or register write) per clock and gives
// exactly one result item for each, in the cycle after acceptance. All channels
// are updated in the same cycle; the interrupt vector comes from the lowest
// expiring channel, settled through the cell chain within that cycle. One
// output register holds the result, so a new item is accepted in every cycle
// except while a held result is stalled.
module four_channel_counter_timer
  import fctc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        operation,
  input  wire logic [CHAN_W-1:0] channel,
  input  wire logic [BYTE_W-1:0] data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      read_data,
  output logic                   irq_valid,
  output logic [BYTE_W-1:0]      irq_vector
);

  logic              accept;
  cell_cmd_t         cmd;
  irq_chain_t        chain [CHANNELS+1];
  logic [BYTE_W-1:0] counts [CHANNELS];
  logic [BYTE_W-1:0] read_mux;

  // Handshake: a new item enters when the output register is free or drains
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Command broadcast
  assign cmd.tick    = accept && (operation == OP_TICK);
  assign cmd.write   = accept && (operation == OP_WRITE);
  assign cmd.channel = channel;
  assign cmd.data    = data;

  assign chain[CHANNELS] = '0;

  // Channel cells, highest channel at the head of the chain
  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    fctc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .index     (CHAN_W'(g)),
      .cmd       (cmd),
      .chain_in  (chain[g+1]),
      .chain_out (chain[g]),
      .count     (counts[g])
    );
  end

  // Count readback; channels not built read as zero
  always_comb begin
    read_mux = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (channel == CHAN_W'(i)) begin
        read_mux = counts[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data  <= (operation == OP_READ) ? read_mux : '0;
      irq_valid  <= (operation == OP_TICK) && chain[0].fired;
      irq_vector <= (operation == OP_TICK) ? chain[0].vector : '0;
    end
  end

  // Every accepted item yields a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // No interrupt means a zero vector
  a_vec_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !irq_valid |-> irq_vector == '0)
    else $error("vector without interrupt");

  // A read result never carries an interrupt
  a_read_no_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != '0) |-> !irq_valid)
    else $error("read result flagged an interrupt");

endmodule

`default_nettype wire

[tb/sv/four_channel_counter_timer_tb.sv]
// Testbench for four_channel_counter_timer: directed and random ticks, reads and
// register writes, checked item by item against an in-bench timer predictor.
// Depends on fctc_pkg and the four_channel_counter_timer RTL.
`timescale 1ns / 1ps

module four_channel_counter_timer_tb;
  import fctc_pkg::*;

  // Operation code 3 is not decoded by the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Control words used by the well-formed programming sequences
  localparam logic [BYTE_W-1:0] CTRL_RUN_TC  = 8'h85;  // enable, constant follows, short
  localparam logic [BYTE_W-1:0] CTRL_SPARE   = 8'h5A;  // bits with no meaning
  localparam logic [BYTE_W-1:0] CTRL_LONG    = 8'h20;
  localparam logic [BYTE_W-1:0] CTRL_IRQ_EN  = 8'h80;
  localparam int RESET_CYCLES = 9;
  localparam int QUIET_TAIL   = 150;  // items at the end with no idling
  localparam int WARM_TICKS   = 4300;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_AFTER   = 300;  // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 50;

  typedef struct {
    logic [1:0]        op;
    logic [CHAN_W-1:0] chan;
    logic [BYTE_W-1:0] value;
  } bus_item_t;

  typedef struct {
    logic [BYTE_W-1:0] count;
    logic              fired;
    logic [BYTE_W-1:0] vector;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        operation = OP_TICK;
  logic [CHAN_W-1:0] channel = '0;
  logic [BYTE_W-1:0] data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] read_data;
  logic              irq_valid;
  logic [BYTE_W-1:0] irq_vector;

  four_channel_counter_timer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .channel(channel), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .irq_valid(irq_valid), .irq_vector(irq_vector)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted timer state, one entry per channel
  logic              irq_en     [CHANNELS];
  logic              tc_next    [CHANNELS];
  logic [BYTE_W-1:0] time_const [CHANNELS];
  logic [BYTE_W-1:0] vec_reg    [CHANNELS];
  logic [BYTE_W-1:0] main_cnt   [CHANNELS];
  logic [BYTE_W-1:0] pre_reload [CHANNELS];
  logic [BYTE_W-1:0] pre_cnt    [CHANNELS];

  bus_item_t     bus_items[$];
  timer_result_t awaited_results[$];
  int total_items = 0;
  int items_sent = 0;
  int results_seen = 0;
  int irqs_seen = 0;
  int errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_armed = 1'b1;
  logic long_hold;

  assign long_hold = (hold_left != 0);

  task automatic reset_timer();
    int i;
    for (i = 0; i < CHANNELS; i++) begin
      irq_en[i]     = 1'b0;
      tc_next[i]    = 1'b0;
      time_const[i] = COUNT_RESET;
      vec_reg[i]    = '0;
      main_cnt[i]   = COUNT_RESET;
      pre_reload[i] = PRESCALE_LONG;
      pre_cnt[i]    = COUNT_RESET;
    end
  endtask

  // Applies one item to the predicted state and returns its result
  function automatic timer_result_t timer_step(logic [1:0] op, logic [CHAN_W-1:0] ch,
                                               logic [BYTE_W-1:0] d);
    timer_result_t r;
    int i;
    r.count  = '0;
    r.fired  = 1'b0;
    r.vector = '0;
    case (op)
      OP_TICK: begin
        // walk from the top channel down so the lowest expiring one wins
        for (i = CHANNELS - 1; i >= 0; i--) begin
          if (irq_en[i]) begin
            pre_cnt[i] = pre_cnt[i] - 1'b1;
            if (pre_cnt[i] == 0) begin
              pre_cnt[i]  = pre_reload[i];
              main_cnt[i] = main_cnt[i] - 1'b1;
              if (main_cnt[i] == 0) begin
                main_cnt[i] = time_const[i];
                r.fired     = 1'b1;
                r.vector    = vec_reg[i];
              end
            end
          end
        end
      end
      OP_READ: begin
        if (ch < CHANNELS) r.count = main_cnt[ch];
      end
      OP_WRITE: begin
        if (ch < CHANNELS) begin
          if (tc_next[ch]) begin
            time_const[ch] = d;
            tc_next[ch]    = 1'b0;
          end else if (d[CW_CONTROL]) begin
            irq_en[ch]     = d[CW_IRQ_EN];
            tc_next[ch]    = d[CW_TC_NEXT];
            pre_reload[ch] = d[CW_RANGE] ? PRESCALE_LONG : PRESCALE_SHORT;
          end else begin
            vec_reg[ch] = {d[BYTE_W-1:3], ch, 1'b0};
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_item(logic [1:0] op, logic [CHAN_W-1:0] ch, logic [BYTE_W-1:0] d);
    bus_item_t it;
    it.op    = op;
    it.chan  = ch;
    it.value = d;
    bus_items.push_back(it);
  endtask

  // Percent chance of starting an idle burst; varies by stretch, none near the end
  function automatic int burst_pct(int done, int left);
    if (left < QUIET_TAIL) return 0;
    case ((done / 200) % 4)
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  task automatic build_stimulus();
    int i;
    int n;
    int pick;
    logic [CHAN_W-1:0] ch;
    logic [BYTE_W-1:0] ctrl;
    // reset values, a tick with every channel off, the unused code
    for (i = 0; i < CHANNELS; i++) queue_item(OP_READ, CHAN_W'(i), 8'h00);
    queue_item(OP_TICK, 2'd0, 8'h00);
    queue_item(OP_UNUSED, 2'd3, 8'hFF);
    // vector writes to every channel, all-zero and near all-ones data among them
    queue_item(OP_WRITE, 2'd0, 8'h00);
    queue_item(OP_WRITE, 2'd1, 8'hFE);
    queue_item(OP_WRITE, 2'd2, 8'h56);
    queue_item(OP_WRITE, 2'd3, 8'hA8);
    // all-ones control word followed by an all-ones constant, then a few ticks
    queue_item(OP_WRITE, 2'd0, 8'hFF);
    queue_item(OP_WRITE, 2'd0, 8'hFF);
    queue_item(OP_TICK, 2'd1, 8'h00);
    queue_item(OP_TICK, 2'd2, 8'hFF);
    queue_item(OP_READ, 2'd0, 8'h00);
    // channels 1 to 3 disabled, zero constant loaded into channel 2 while off, channel 0 enabled
    queue_item(OP_WRITE, 2'd1, 8'h01);
    queue_item(OP_WRITE, 2'd2, 8'h05);
    queue_item(OP_WRITE, 2'd2, 8'h00);
    queue_item(OP_WRITE, 2'd3, 8'h21);
    queue_item(OP_WRITE, 2'd0, 8'h81);
    queue_item(OP_TICK, 2'd0, 8'h00);
    queue_item(OP_READ, 2'd2, 8'h00);

    // Warm-up: main counts start at 255, so a long tick run is needed before
    // anything expires. Channels 1 to 3 start in step so they expire together;
    // channel 3 gets a zero constant and is read every tick around its expiry.
    for (i = 0; i < CHANNELS; i++) queue_item(OP_WRITE, CHAN_W'(i), 8'(16 * (i + 1)));
    queue_item(OP_WRITE, 2'd0, CTRL_RUN_TC);
    queue_item(OP_WRITE, 2'd0, 8'd1);
    queue_item(OP_WRITE, 2'd1, CTRL_RUN_TC);
    queue_item(OP_WRITE, 2'd1, 8'd2);
    queue_item(OP_WRITE, 2'd2, CTRL_RUN_TC);
    queue_item(OP_WRITE, 2'd2, 8'd2);
    queue_item(OP_WRITE, 2'd3, CTRL_RUN_TC);
    queue_item(OP_WRITE, 2'd3, 8'd0);
    for (i = 0; i < WARM_TICKS; i++) begin
      queue_item(OP_TICK, CHAN_W'($urandom), 8'($urandom));
      if (i >= 4040 && i <= 4110) queue_item(OP_READ, 2'd3, 8'($urandom));
      else if ($urandom_range(0, 29) == 0) queue_item(OP_READ, CHAN_W'($urandom), 8'($urandom));
    end

    // Random part: mostly ticks, reads and well-formed reprogramming
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      ch = CHAN_W'($urandom);
      if (pick < 55) begin
        queue_item(OP_TICK, ch, 8'($urandom));
        n++;
      end else if (pick < 70) begin
        queue_item(OP_READ, ch, 8'($urandom));
        n++;
      end else if (pick < 85) begin
        ctrl = CTRL_RUN_TC | (8'($urandom) & CTRL_SPARE);
        if ($urandom_range(0, 7) == 0) ctrl = ctrl | CTRL_LONG;
        if ($urandom_range(0, 7) == 0) ctrl = ctrl & ~CTRL_IRQ_EN;
        queue_item(OP_WRITE, ch, ctrl);
        if ($urandom_range(0, 15) == 0) queue_item(OP_WRITE, ch, 8'($urandom));
        else queue_item(OP_WRITE, ch, 8'($urandom_range(1, 4)));
        n += 2;
      end else if (pick < 90) begin
        queue_item(OP_WRITE, ch, 8'($urandom) & 8'hFE);
        n++;
      end else if (pick < 97) begin
        queue_item(OP_WRITE, ch, 8'($urandom));
        n++;
      end else begin
        queue_item(OP_UNUSED, ch, 8'($urandom));
        n++;
      end
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at result %0d: %s = %0h, expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  // Driver: presents pending items, holds them while stalled, idles in bursts
  always @(posedge clk) begin
    bus_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      reset_timer();
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(timer_step(operation, channel, data));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && !long_hold) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (bus_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!long_hold &&
                     $urandom_range(0, 99) < burst_pct(items_sent, bus_items.size())) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 3);
        end else begin
          it = bus_items.pop_front();
          in_valid  <= 1'b1;
          operation <= it.op;
          channel   <= it.chan;
          data      <= it.value;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction
  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no item outstanding", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (read_data !== want.count) report_mismatch("read_data", read_data, want.count);
          if (irq_valid !== want.fired) report_mismatch("irq_valid", irq_valid, want.fired);
          if (irq_vector !== want.vector) report_mismatch("irq_vector", irq_vector, want.vector);
          if (want.fired) irqs_seen++;
        end
        results_seen++;
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < burst_pct(results_seen, total_items - results_seen))
      begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, so the output register fills and input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && results_seen >= HOLD_AFTER) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Run control
  initial begin
    build_stimulus();
    total_items = bus_items.size();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (bus_items.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (8) @(posedge clk);
    $display("%0d items through all four channels, %0d results checked, %0d interrupts",
             items_sent, results_seen, irqs_seen);
    $display("covered reset reads, vector and control writes, zero constant, priority, stalls");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
